[design/splsch_pkg.sv]
// Shared constants and controller/datapath interface types for the priority list scheduler.
`timescale 1ns / 1ps
package splsch_pkg;

  localparam int DEF_NUM_ENTRIES = 64;

  localparam int IN_W  = 104;
  localparam int OUT_W = 112;

  // opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // memory read address select
  localparam logic [1:0] RD_K     = 2'd0;
  localparam logic [1:0] RD_HEAD  = 2'd1;
  localparam logic [1:0] RD_CUR   = 2'd2;
  localparam logic [1:0] RD_LINKQ = 2'd3;

  // link write address / data selects
  localparam logic       LWA_K     = 1'b0;
  localparam logic       LWA_PREV  = 1'b1;
  localparam logic [1:0] LWD_CUR   = 2'd0;
  localparam logic [1:0] LWD_KNEXT = 2'd1;
  localparam logic [1:0] LWD_K     = 2'd2;

  // head load select
  localparam logic [1:0] HD_KNEXT = 2'd0;
  localparam logic [1:0] HD_K     = 2'd1;
  localparam logic [1:0] HD_LINKQ = 2'd2;

  // prev load select
  localparam logic [1:0] PV_NONE  = 2'd0;
  localparam logic [1:0] PV_HEAD  = 2'd1;
  localparam logic [1:0] PV_CUR   = 2'd2;
  localparam logic [1:0] PV_LINKQ = 2'd3;

  // cur load select
  localparam logic CU_HEAD  = 1'b0;
  localparam logic CU_LINKQ = 1'b1;

  // count write select
  localparam logic CN_AVAIL = 1'b0;
  localparam logic CN_SUM   = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       status_ld;
    logic [1:0] status_val;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_prio;
    logic       wr_count;
    logic       count_sel;
    logic       wr_link;
    logic       link_addr_sel;
    logic [1:0] link_data_sel;
    logic       set_valid;
    logic       clr_valid_k;
    logic       clr_valid_head;
    logic       head_ld;
    logic [1:0] head_sel;
    logic       prev_ld;
    logic [1:0] prev_sel;
    logic       cur_ld;
    logic       cur_sel;
    logic       knext_ld;
    logic       out_ld;
    logic       out_zero;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       id_ok;
    logic       valid_k;
    logic       head_none;
    logic       head_is_k;
    logic       prio_eq;
    logic       prio_lt;
    logic       linkq_is_k;
    logic       cur_none;
    logic       prev_none;
    logic       out_free;
  } stat_t;

endpackage

[design/splsch_dp.sv]
// Datapath: entry memories, valid bits, list pointers and result register.
`timescale 1ns / 1ps
module splsch_dp import splsch_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int IW = $clog2(NUM_ENTRIES + 1);
  localparam logic [IW-1:0] NONE = IW'(NUM_ENTRIES);

  // captured request
  logic [1:0]  req_op;
  logic [5:0]  req_id;
  logic [63:0] req_prio;
  logic [31:0] req_avail;

  logic [AW+5:0] id_wide;
  logic [AW-1:0] k;
  logic [IW-1:0] k_iw;
  logic          id_ok;

  // list state
  logic [NUM_ENTRIES-1:0] valid_bits;
  logic [IW-1:0] head, cur, prev, knext;

  // entry memories
  logic [63:0]   prio_mem  [NUM_ENTRIES];
  logic [31:0]   count_mem [NUM_ENTRIES];
  logic [IW-1:0] link_mem  [NUM_ENTRIES];
  logic [63:0]   prio_q;
  logic [31:0]   count_q;
  logic [IW-1:0] link_q;
  logic [AW-1:0] rd_addr, wr_link_addr;
  logic [IW-1:0] wr_link_data;

  // result register
  logic [1:0]  res_status;
  logic [1:0]  out_status;
  logic        out_present;
  logic [5:0]  out_id;
  logic [63:0] out_prio;
  logic [31:0] out_avail;
  logic [IW+5:0] head_wide;

  assign id_wide = {{AW{1'b0}}, req_id};
  assign k       = id_wide[AW-1:0];
  assign k_iw    = IW'(k);
  assign id_ok   = {26'd0, req_id} < 32'(NUM_ENTRIES);
  assign head_wide = {6'd0, head};

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op    <= s_tdata[1:0];
      req_id    <= s_tdata[7:2];
      req_prio  <= s_tdata[71:8];
      req_avail <= s_tdata[103:72];
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_K:     rd_addr = k;
      RD_HEAD:  rd_addr = head[AW-1:0];
      RD_CUR:   rd_addr = cur[AW-1:0];
      RD_LINKQ: rd_addr = link_q[AW-1:0];
      default:  rd_addr = k;
    endcase
  end

  // link write address and data
  always_comb begin
    wr_link_addr = (cmd.link_addr_sel == LWA_PREV) ? prev[AW-1:0] : k;
    case (cmd.link_data_sel)
      LWD_CUR:   wr_link_data = cur;
      LWD_KNEXT: wr_link_data = knext;
      LWD_K:     wr_link_data = k_iw;
      default:   wr_link_data = cur;
    endcase
  end

  // memory ports, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      prio_q  <= prio_mem[rd_addr];
      count_q <= count_mem[rd_addr];
      link_q  <= link_mem[rd_addr];
    end
    if (cmd.wr_prio) prio_mem[k] <= req_prio;
    if (cmd.wr_count)
      count_mem[k] <= (cmd.count_sel == CN_SUM) ? count_q + req_avail : req_avail;
    if (cmd.wr_link) link_mem[wr_link_addr] <= wr_link_data;
  end

  // walk pointers
  always_ff @(posedge clk) begin
    if (cmd.knext_ld) knext <= link_q;
    if (cmd.cur_ld) cur <= (cmd.cur_sel == CU_LINKQ) ? link_q : head;
    if (cmd.prev_ld) begin
      case (cmd.prev_sel)
        PV_NONE:  prev <= NONE;
        PV_HEAD:  prev <= head;
        PV_CUR:   prev <= cur;
        PV_LINKQ: prev <= link_q;
        default:  prev <= NONE;
      endcase
    end
  end

  // head pointer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= NONE;
      valid_bits <= '0;
    end else begin
      if (cmd.head_ld) begin
        case (cmd.head_sel)
          HD_KNEXT: head <= knext;
          HD_K:     head <= k_iw;
          HD_LINKQ: head <= link_q;
          default:  head <= knext;
        endcase
      end
      if (cmd.set_valid)      valid_bits[k] <= 1'b1;
      if (cmd.clr_valid_k)    valid_bits[k] <= 1'b0;
      if (cmd.clr_valid_head) valid_bits[head[AW-1:0]] <= 1'b0;
    end
  end

  // status of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.status_ld) res_status <= cmd.status_val;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld || cmd.out_zero) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status  <= res_status;
      out_present <= 1'b1;
      out_id      <= head_wide[5:0];
      out_prio    <= prio_q;
      out_avail   <= count_q;
    end else if (cmd.out_zero) begin
      out_status  <= res_status;
      out_present <= 1'b0;
      out_id      <= '0;
      out_prio    <= '0;
      out_avail   <= '0;
    end
  end

  assign m_tdata = {7'd0, out_avail, out_prio, out_id, out_present, out_status};

  // status to the controller
  always_comb begin
    stat.op         = req_op;
    stat.id_ok      = id_ok;
    stat.valid_k    = id_ok && valid_bits[k];
    stat.head_none  = (head == NONE);
    stat.head_is_k  = (head == k_iw);
    stat.prio_eq    = (prio_q == req_prio);
    stat.prio_lt    = (prio_q < req_prio);
    stat.linkq_is_k = (link_q == k_iw);
    stat.cur_none   = (cur == NONE);
    stat.prev_none  = (prev == NONE);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

[design/splsch_ctrl.sv]
// Controller: sequences decode, list walks, relinking and the result load.
`timescale 1ns / 1ps
module splsch_ctrl import splsch_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_UPD_WAIT  = 4'd2;
  localparam logic [3:0] S_UNL_K     = 4'd3;
  localparam logic [3:0] S_UNL_BEGIN = 4'd4;
  localparam logic [3:0] S_UNL_WALK  = 4'd5;
  localparam logic [3:0] S_UNL_DONE  = 4'd6;
  localparam logic [3:0] S_LINK_CHK  = 4'd7;
  localparam logic [3:0] S_LINK_CMP  = 4'd8;
  localparam logic [3:0] S_LINK_INS  = 4'd9;
  localparam logic [3:0] S_LINK_PREV = 4'd10;
  localparam logic [3:0] S_POP_WAIT  = 4'd11;
  localparam logic [3:0] S_FINISH    = 4'd12;
  localparam logic [3:0] S_RES_WAIT  = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture    = 1'b1;
          cmd.status_ld  = 1'b1;
          cmd.status_val = ST_OK;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_ADD: begin
            if (stat.id_ok && stat.valid_k) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_K;
              state_next = S_UPD_WAIT;
            end else if (stat.id_ok) begin
              cmd.wr_prio   = 1'b1;
              cmd.wr_count  = 1'b1;
              cmd.count_sel = CN_AVAIL;
              cmd.set_valid = 1'b1;
              cmd.cur_ld    = 1'b1;
              cmd.cur_sel   = CU_HEAD;
              cmd.prev_ld   = 1'b1;
              cmd.prev_sel  = PV_NONE;
              state_next    = S_LINK_CHK;
            end
          end
          OP_POP: begin
            if (stat.head_none) begin
              cmd.status_ld  = 1'b1;
              cmd.status_val = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_next = S_POP_WAIT;
            end
          end
          OP_REMOVE: begin
            if (stat.valid_k) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_K;
              state_next = S_UNL_K;
            end else begin
              cmd.status_ld  = 1'b1;
              cmd.status_val = ST_ABSENT;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      // existing entry: sum avail, relink only on a priority change
      S_UPD_WAIT: begin
        cmd.wr_count  = 1'b1;
        cmd.count_sel = CN_SUM;
        if (stat.prio_eq) begin
          state_next = S_FINISH;
        end else begin
          cmd.knext_ld = 1'b1;
          state_next   = S_UNL_BEGIN;
        end
      end
      S_UNL_K: begin
        cmd.knext_ld = 1'b1;
        state_next   = S_UNL_BEGIN;
      end
      S_UNL_BEGIN: begin
        if (stat.head_is_k) begin
          cmd.head_ld  = 1'b1;
          cmd.head_sel = HD_KNEXT;
          state_next   = S_UNL_DONE;
        end else begin
          cmd.prev_ld  = 1'b1;
          cmd.prev_sel = PV_HEAD;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_HEAD;
          state_next   = S_UNL_WALK;
        end
      end
      // look for the predecessor of the entry being unlinked
      S_UNL_WALK: begin
        if (stat.linkq_is_k) begin
          cmd.wr_link       = 1'b1;
          cmd.link_addr_sel = LWA_PREV;
          cmd.link_data_sel = LWD_KNEXT;
          state_next        = S_UNL_DONE;
        end else begin
          cmd.prev_ld  = 1'b1;
          cmd.prev_sel = PV_LINKQ;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_LINKQ;
        end
      end
      S_UNL_DONE: begin
        if (stat.op == OP_ADD) begin
          cmd.wr_prio  = 1'b1;
          cmd.cur_ld   = 1'b1;
          cmd.cur_sel  = CU_HEAD;
          cmd.prev_ld  = 1'b1;
          cmd.prev_sel = PV_NONE;
          state_next   = S_LINK_CHK;
        end else begin
          cmd.clr_valid_k = 1'b1;
          state_next      = S_FINISH;
        end
      end
      // find first entry whose priority is not smaller
      S_LINK_CHK: begin
        if (stat.cur_none) begin
          state_next = S_LINK_INS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_LINK_CMP;
        end
      end
      S_LINK_CMP: begin
        if (stat.prio_lt) begin
          cmd.prev_ld  = 1'b1;
          cmd.prev_sel = PV_CUR;
          cmd.cur_ld   = 1'b1;
          cmd.cur_sel  = CU_LINKQ;
          state_next   = S_LINK_CHK;
        end else begin
          state_next = S_LINK_INS;
        end
      end
      S_LINK_INS: begin
        cmd.wr_link       = 1'b1;
        cmd.link_addr_sel = LWA_K;
        cmd.link_data_sel = LWD_CUR;
        if (stat.prev_none) begin
          cmd.head_ld  = 1'b1;
          cmd.head_sel = HD_K;
          state_next   = S_FINISH;
        end else begin
          state_next = S_LINK_PREV;
        end
      end
      S_LINK_PREV: begin
        cmd.wr_link       = 1'b1;
        cmd.link_addr_sel = LWA_PREV;
        cmd.link_data_sel = LWD_K;
        state_next        = S_FINISH;
      end
      S_POP_WAIT: begin
        cmd.clr_valid_head = 1'b1;
        cmd.head_ld        = 1'b1;
        cmd.head_sel       = HD_LINKQ;
        state_next         = S_FINISH;
      end
      // report the head once the output register is free
      S_FINISH: begin
        if (stat.head_none) begin
          if (stat.out_free) begin
            cmd.out_zero = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_RES_WAIT;
        end
      end
      S_RES_WAIT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/sorted_priority_list_scheduler.sv]
// Top level of the sorted priority list scheduler.
// Entries are kept by id in a singly linked list sorted by ascending priority,
// smallest first, a new entry going ahead of equal priorities. Each input
// transaction (add/update, pop, remove) yields one result transaction giving the
// status and the head after the operation. One transaction is worked at a time.
// Both list walks read one entry memory location per visit. The insertion walk
// reads an entry in its check state and compares it in its compare state; the
// unlink walk reads and checks an entry in its walk state. The next transaction
// is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
module sorted_priority_list_scheduler import splsch_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode[1:0], entry_id[7:2], entry_priority[71:8], entry_avail[103:72]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[1:0], head_present[2], head_id[8:3], head_priority[72:9],
  // head_avail[104:73], zero fill above
  output logic [OUT_W-1:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  splsch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  splsch_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  // one transaction in flight: input closes straight after acceptance
  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // empty list reports zero head fields
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[104:3] == '0)
    else $error("empty head fields not zero");

  // pop on empty list cannot leave a head
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_EMPTY |-> !m_tdata[2])
    else $error("empty status with head present");

endmodule
